// ----- hdl/bim_pkg.sv -----
// ----------------------------------------------------------------------------
// bim_pkg
// shared constants, register indexes and control types for the raw moments
// core
// ----------------------------------------------------------------------------
package bim_pkg;

  localparam int MAX_DIM = 1024;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int SIZE_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int CUBE_W  = 3 * COORD_W;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int PIXEL_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     SIZE_RESET       = 11'd1024;

  localparam int AREA_W    = 21;
  localparam int SUM_X_W   = 29;
  localparam int SUM_Y_W   = 29;
  localparam int SUM_XY_W  = 38;
  localparam int SUM_XX_W  = 39;
  localparam int SUM_YY_W  = 39;
  localparam int SUM_XXY_W = 48;
  localparam int SUM_XYY_W = 48;
  localparam int SUM_XXX_W = 48;
  localparam int SUM_YYY_W = 48;

  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic accumulate;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic out_blocked;
  } status_t;

endpackage

// ----- hdl/bim_ctrl.sv -----
// ----------------------------------------------------------------------------
// bim_ctrl
// sequencer for one pixel word: capture, two multiply steps, accumulate
// ----------------------------------------------------------------------------
module bim_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  bim_pkg::status_t status,
  output bim_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL1 = 2'd1;
  localparam logic [1:0] ST_MUL2 = 2'd2;
  localparam logic [1:0] ST_ACC  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       acc_go;

  assign acc_go = !(status.frame_end && status.out_blocked);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    pixel_ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        pixel_ready = 1'b1;
        if (pixel_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (acc_go) begin
          cmd.accumulate = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/bim_datapath.sv -----
// ----------------------------------------------------------------------------
// bim_datapath
// frame size registers, position counters, coordinate products, moment sums
// and the result register
// ----------------------------------------------------------------------------
module bim_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bim_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bim_pkg::CFG_W-1:0]          cfg_data,
  input  logic [bim_pkg::PIXEL_W-1:0]        pixel,
  input  bim_pkg::cmd_t                      cmd,
  output bim_pkg::status_t                   status,
  input  logic                               result_ready,
  output logic                               result_valid,
  output logic [bim_pkg::AREA_W-1:0]         area,
  output logic [bim_pkg::SUM_X_W-1:0]        sum_x,
  output logic [bim_pkg::SUM_Y_W-1:0]        sum_y,
  output logic [bim_pkg::SUM_XY_W-1:0]       sum_xy,
  output logic [bim_pkg::SUM_XX_W-1:0]       sum_xx,
  output logic [bim_pkg::SUM_YY_W-1:0]       sum_yy,
  output logic [bim_pkg::SUM_XXY_W-1:0]      sum_xxy,
  output logic [bim_pkg::SUM_XYY_W-1:0]      sum_xyy,
  output logic [bim_pkg::SUM_XXX_W-1:0]      sum_xxx,
  output logic [bim_pkg::SUM_YYY_W-1:0]      sum_yyy
);

  logic [bim_pkg::CFG_W-1:0]   frame_width;
  logic [bim_pkg::CFG_W-1:0]   frame_height;
  logic [bim_pkg::SIZE_W-1:0]  width_eff;
  logic [bim_pkg::SIZE_W-1:0]  height_eff;
  logic                        last_col;
  logic                        last_row;

  logic [bim_pkg::COORD_W-1:0] column;
  logic [bim_pkg::COORD_W-1:0] row;

  logic                        set;
  logic [bim_pkg::SQ_W-1:0]    p_xy;
  logic [bim_pkg::SQ_W-1:0]    p_xx;
  logic [bim_pkg::SQ_W-1:0]    p_yy;
  logic [bim_pkg::CUBE_W-1:0]  p_xxy;
  logic [bim_pkg::CUBE_W-1:0]  p_xyy;
  logic [bim_pkg::CUBE_W-1:0]  p_xxx;
  logic [bim_pkg::CUBE_W-1:0]  p_yyy;

  logic [bim_pkg::AREA_W-1:0]    acc_area,    acc_area_next;
  logic [bim_pkg::SUM_X_W-1:0]   acc_x,       acc_x_next;
  logic [bim_pkg::SUM_Y_W-1:0]   acc_y,       acc_y_next;
  logic [bim_pkg::SUM_XY_W-1:0]  acc_xy,      acc_xy_next;
  logic [bim_pkg::SUM_XX_W-1:0]  acc_xx,      acc_xx_next;
  logic [bim_pkg::SUM_YY_W-1:0]  acc_yy,      acc_yy_next;
  logic [bim_pkg::SUM_XXY_W-1:0] acc_xxy,     acc_xxy_next;
  logic [bim_pkg::SUM_XYY_W-1:0] acc_xyy,     acc_xyy_next;
  logic [bim_pkg::SUM_XXX_W-1:0] acc_xxx,     acc_xxx_next;
  logic [bim_pkg::SUM_YYY_W-1:0] acc_yyy,     acc_yyy_next;

  // zero size counts as one, oversize saturates
  always_comb begin
    if (frame_width == '0) begin
      width_eff = bim_pkg::SIZE_W'(1);
    end else if (int'(frame_width) > bim_pkg::MAX_DIM) begin
      width_eff = bim_pkg::SIZE_W'(bim_pkg::MAX_DIM);
    end else begin
      width_eff = bim_pkg::SIZE_W'(frame_width);
    end
    if (frame_height == '0) begin
      height_eff = bim_pkg::SIZE_W'(1);
    end else if (int'(frame_height) > bim_pkg::MAX_DIM) begin
      height_eff = bim_pkg::SIZE_W'(bim_pkg::MAX_DIM);
    end else begin
      height_eff = bim_pkg::SIZE_W'(frame_height);
    end
  end

  assign last_col = bim_pkg::SIZE_W'(column) >= (width_eff - bim_pkg::SIZE_W'(1));
  assign last_row = bim_pkg::SIZE_W'(row) >= (height_eff - bim_pkg::SIZE_W'(1));

  assign status.frame_end   = last_col && last_row;
  assign status.out_blocked = result_valid && !result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bim_pkg::SIZE_RESET;
      frame_height <= bim_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bim_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        bim_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // product pipeline, payload only
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set <= (pixel != '0);
    end
    if (cmd.mul1) begin
      p_xy <= bim_pkg::SQ_W'(column) * bim_pkg::SQ_W'(row);
      p_xx <= bim_pkg::SQ_W'(column) * bim_pkg::SQ_W'(column);
      p_yy <= bim_pkg::SQ_W'(row) * bim_pkg::SQ_W'(row);
    end
    if (cmd.mul2) begin
      p_xxy <= bim_pkg::CUBE_W'(p_xx) * bim_pkg::CUBE_W'(row);
      p_xyy <= bim_pkg::CUBE_W'(p_xy) * bim_pkg::CUBE_W'(row);
      p_xxx <= bim_pkg::CUBE_W'(p_xx) * bim_pkg::CUBE_W'(column);
      p_yyy <= bim_pkg::CUBE_W'(p_yy) * bim_pkg::CUBE_W'(row);
    end
  end

  always_comb begin
    acc_area_next = acc_area;
    acc_x_next    = acc_x;
    acc_y_next    = acc_y;
    acc_xy_next   = acc_xy;
    acc_xx_next   = acc_xx;
    acc_yy_next   = acc_yy;
    acc_xxy_next  = acc_xxy;
    acc_xyy_next  = acc_xyy;
    acc_xxx_next  = acc_xxx;
    acc_yyy_next  = acc_yyy;
    if (set) begin
      acc_area_next = acc_area + bim_pkg::AREA_W'(1);
      acc_x_next    = acc_x   + bim_pkg::SUM_X_W'(column);
      acc_y_next    = acc_y   + bim_pkg::SUM_Y_W'(row);
      acc_xy_next   = acc_xy  + bim_pkg::SUM_XY_W'(p_xy);
      acc_xx_next   = acc_xx  + bim_pkg::SUM_XX_W'(p_xx);
      acc_yy_next   = acc_yy  + bim_pkg::SUM_YY_W'(p_yy);
      acc_xxy_next  = acc_xxy + bim_pkg::SUM_XXY_W'(p_xxy);
      acc_xyy_next  = acc_xyy + bim_pkg::SUM_XYY_W'(p_xyy);
      acc_xxx_next  = acc_xxx + bim_pkg::SUM_XXX_W'(p_xxx);
      acc_yyy_next  = acc_yyy + bim_pkg::SUM_YYY_W'(p_yyy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      row      <= '0;
      acc_area <= '0;
      acc_x    <= '0;
      acc_y    <= '0;
      acc_xy   <= '0;
      acc_xx   <= '0;
      acc_yy   <= '0;
      acc_xxy  <= '0;
      acc_xyy  <= '0;
      acc_xxx  <= '0;
      acc_yyy  <= '0;
    end else if (cmd.accumulate) begin
      if (!last_col) begin
        column <= column + bim_pkg::COORD_W'(1);
      end else begin
        column <= '0;
        if (!last_row) begin
          row <= row + bim_pkg::COORD_W'(1);
        end else begin
          row <= '0;
        end
      end
      if (status.frame_end) begin
        acc_area <= '0;
        acc_x    <= '0;
        acc_y    <= '0;
        acc_xy   <= '0;
        acc_xx   <= '0;
        acc_yy   <= '0;
        acc_xxy  <= '0;
        acc_xyy  <= '0;
        acc_xxx  <= '0;
        acc_yyy  <= '0;
      end else begin
        acc_area <= acc_area_next;
        acc_x    <= acc_x_next;
        acc_y    <= acc_y_next;
        acc_xy   <= acc_xy_next;
        acc_xx   <= acc_xx_next;
        acc_yy   <= acc_yy_next;
        acc_xxy  <= acc_xxy_next;
        acc_xyy  <= acc_xyy_next;
        acc_xxx  <= acc_xxx_next;
        acc_yyy  <= acc_yyy_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.accumulate && status.frame_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accumulate && status.frame_end) begin
      area    <= acc_area_next;
      sum_x   <= acc_x_next;
      sum_y   <= acc_y_next;
      sum_xy  <= acc_xy_next;
      sum_xx  <= acc_xx_next;
      sum_yy  <= acc_yy_next;
      sum_xxy <= acc_xxy_next;
      sum_xyy <= acc_xyy_next;
      sum_xxx <= acc_xxx_next;
      sum_yyy <= acc_yyy_next;
    end
  end

endmodule

// ----- hdl/binary_image_raw_moments_core.sv -----
// ----------------------------------------------------------------------------
// binary_image_raw_moments_core
// raw moments of orders 0 to 3 over a binary image streamed in raster order
// ----------------------------------------------------------------------------
// Each pixel word goes through four steps: accept, two multiply steps that
// form the coordinate products, and one accumulate step; a new pixel is
// accepted only after the previous one has finished them. The column and row
// are counted inside from frame_width and frame_height (a size of zero acts
// as one, a size above 1024 acts as 1024). On the last pixel of a frame the
// ten sums, that pixel included, are loaded into the result register and the
// sums and position clear; the next pixel is accepted while the result
// waits; the core holds only if a new frame ends before that result is
// taken. Size registers must be written while the core is idle; not enforced.
// ----------------------------------------------------------------------------
module binary_image_raw_moments_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bim_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bim_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  logic [bim_pkg::PIXEL_W-1:0]        pixel,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [bim_pkg::AREA_W-1:0]         area,
  output logic [bim_pkg::SUM_X_W-1:0]        sum_x,
  output logic [bim_pkg::SUM_Y_W-1:0]        sum_y,
  output logic [bim_pkg::SUM_XY_W-1:0]       sum_xy,
  output logic [bim_pkg::SUM_XX_W-1:0]       sum_xx,
  output logic [bim_pkg::SUM_YY_W-1:0]       sum_yy,
  output logic [bim_pkg::SUM_XXY_W-1:0]      sum_xxy,
  output logic [bim_pkg::SUM_XYY_W-1:0]      sum_xyy,
  output logic [bim_pkg::SUM_XXX_W-1:0]      sum_xxx,
  output logic [bim_pkg::SUM_YYY_W-1:0]      sum_yyy
);

  bim_pkg::cmd_t    cmd;
  bim_pkg::status_t status;

  bim_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .status      (status),
    .cmd         (cmd)
  );

  bim_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (pixel),
    .cmd          (cmd),
    .status       (status),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .area         (area),
    .sum_x        (sum_x),
    .sum_y        (sum_y),
    .sum_xy       (sum_xy),
    .sum_xx       (sum_xx),
    .sum_yy       (sum_yy),
    .sum_xxy      (sum_xxy),
    .sum_xyy      (sum_xyy),
    .sum_xxx      (sum_xxx),
    .sum_yyy      (sum_yyy)
  );

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.mul1, cmd.mul2, cmd.accumulate}))
    else $error("more than one datapath command at once");

  assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel_ready) |=> !pixel_ready ##1 !pixel_ready ##1 !pixel_ready)
    else $error("pixel accepted during the multiply sequence");

  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.accumulate && status.frame_end))
    else $error("result word raised without a frame end");

  assert property (@(posedge clk) disable iff (rst)
    cmd.accumulate |-> !(status.frame_end && status.out_blocked))
    else $error("frame end would overwrite a pending result word");
`endif

endmodule
